// File: rtl/dh_forward_kinematics_6dof_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the six-joint forward kinematics block
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DH_FORWARD_KINEMATICS_6DOF_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_6DOF_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DH6_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DH6_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DH6_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DH6_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/dh6_pkg.sv
// ----------------------------------------------------------------------------
// dh6_pkg
// Types, constants and helpers shared by the kinematics chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dh6_pkg;

   localparam int ROT_W = 18;
   localparam int POS_W = 40;
   localparam int RND_W = 56;
   localparam int NUM_JOINTS = 6;

   typedef enum logic [2:0] {
      CSR_BASE_HEIGHT      = 3'd0,
      CSR_UPPER_ARM_LENGTH = 3'd1,
      CSR_ELBOW_LENGTH     = 3'd2,
      CSR_FOREARM_OFFSET   = 3'd3,
      CSR_WRIST_LENGTH     = 3'd4,
      CSR_TOOL_OFFSET      = 3'd5,
      CSR_SHOULDER_OFFSET  = 3'd6,
      CSR_ELBOW_OFFSET     = 3'd7
   } csr_index_type;

   localparam logic signed [1:0] TW_COS [NUM_JOINTS] = '{2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] TW_SIN [NUM_JOINTS] = '{2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1};

   // joint angles (next joint at index 0), rotation row major, position Q17.22
   typedef struct packed {
      logic [NUM_JOINTS-1:0][15:0] ang;
      logic [8:0][ROT_W-1:0]       rot;
      logic [2:0][POS_W-1:0]       pos;
   } link_type;

   typedef struct packed {
      logic        neg;
      logic [15:0] x;
   } fold_type;

   function automatic fold_type fold(input logic [31:0] phase);
      fold_type   f;
      logic [30:0] xr;
      if (phase[30]) begin
         xr = 31'h4000_0000 - {1'b0, phase[29:0]};
      end else begin
         xr = {1'b0, phase[29:0]};
      end
      f.neg = phase[31];
      f.x   = xr[30:15];
      return f;
   endfunction

   function automatic logic signed [16:0] twist_mul(input logic signed [16:0] v,
                                                    input logic signed [1:0] t);
      logic signed [16:0] r;
      case (t)
         2'sd1:   r = v;
         -2'sd1:  r = -v;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round half away from zero by 14 bits
   function automatic logic signed [RND_W-1:0] rnd14(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] r;
      if (v >= 0) begin
         r = (v + RND_W'(8192)) >>> 14;
      end else begin
         r = -((-v + RND_W'(8192)) >>> 14);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/dh6_cell.sv
// ----------------------------------------------------------------------------
// dh6_cell
// One joint of the chain: sine/cosine of the joint angle, then the product of
// the incoming transform with the joint's DH transform. Eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dh6_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire dh6_pkg::link_type in_data,
   input  wire logic [15:0]       len_a,
   input  wire logic [15:0]       len_d,
   input  wire logic signed [1:0] tw_cos,
   input  wire logic signed [1:0] tw_sin,
   output logic                   out_valid,
   output dh6_pkg::link_type      out_data
);

   localparam int NS = 8;
   localparam int RW = dh6_pkg::ROT_W;
   localparam int PW = dh6_pkg::POS_W;
   localparam int DW = dh6_pkg::RND_W;

   logic [NS-1:0]      vld_ff;
   dh6_pkg::link_type  lnk_ff [NS];
   dh6_pkg::link_type  lnk8_in;

   // index 0: sine, index 1: cosine
   logic [15:0] x1_ff [2], x2_ff [2], x3_ff [2];
   logic [31:0] xx1_ff [2];
   logic [15:0] q2_ff [2];
   logic [27:0] p2_ff [2];
   logic [30:0] p3_ff [2];
   logic [31:0] p4_ff [2];
   logic        ng1_ff [2], ng2_ff [2], ng3_ff [2], ng4_ff [2];
   logic signed [16:0] sc5_ff [2];

   logic signed [34:0] prod6_ff [3][3][3];
   logic signed [33:0] lp6_ff [3];
   logic signed [RW-1:0] nr7_ff [9];
   logic signed [51:0] pp7_ff [3][3];

   dh6_pkg::fold_type  fd_in [2];
   logic [31:0]        xx1_in [2];
   logic [15:0]        q2_in [2];
   logic [27:0]        p2_in [2];
   logic [30:0]        p3_in [2];
   logic [31:0]        p4_in [2];
   logic signed [16:0] sc5_in [2];
   logic signed [16:0] m6 [3][3];
   logic signed [34:0] prod6_in [3][3][3];
   logic signed [33:0] lp6_in [3];
   logic signed [RW-1:0] nr7_in [9];
   logic signed [51:0] pp7_in [3][3];

   always_comb begin
      logic [31:0] ph;
      logic [14:0] t1;
      logic [15:0] t2;
      logic [16:0] f;
      logic [15:0] v;
      ph = {in_data.ang[0], 16'h0};
      fd_in[0] = dh6_pkg::fold(ph);
      fd_in[1] = dh6_pkg::fold(ph + 32'h4000_0000);
      for (int u = 0; u < 2; u++) begin
         xx1_in[u] = fd_in[u].x * fd_in[u].x;
         q2_in[u]  = xx1_ff[u][30:15];
         p2_in[u]  = 28'(q2_in[u] * 16'd2320);
         t1        = 15'(15'd21024 - 15'(p2_ff[u][27:15]));
         p3_in[u]  = 31'(q2_ff[u] * t1);
         t2        = 16'(16'd51472 - p3_ff[u][30:15]);
         p4_in[u]  = x3_ff[u] * t2;
         f         = p4_ff[u][31:15];
         v         = 16'((f + 17'd1) >> 1);
         sc5_in[u] = ng4_ff[u] ? -$signed({1'b0, v}) : $signed({1'b0, v});
      end
   end

   always_comb begin
      logic signed [16:0] s;
      logic signed [16:0] c;
      s = sc5_ff[0];
      c = sc5_ff[1];
      m6[0][0] = c;
      m6[0][1] = -dh6_pkg::twist_mul(s, tw_cos);
      m6[0][2] = dh6_pkg::twist_mul(s, tw_sin);
      m6[1][0] = s;
      m6[1][1] = dh6_pkg::twist_mul(c, tw_cos);
      m6[1][2] = -dh6_pkg::twist_mul(c, tw_sin);
      m6[2][0] = '0;
      m6[2][1] = dh6_pkg::twist_mul(17'sd16384, tw_sin);
      m6[2][2] = dh6_pkg::twist_mul(17'sd16384, tw_cos);
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               prod6_in[r][k][j] = $signed(lnk_ff[4].rot[r*3+j]) * m6[j][k];
            end
         end
      end
      lp6_in[0] = $signed({1'b0, len_a}) * c;
      lp6_in[1] = $signed({1'b0, len_a}) * s;
      lp6_in[2] = $signed({4'b0, len_d, 14'b0});
   end

   always_comb begin
      logic signed [DW-1:0] sum;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            sum = DW'(prod6_ff[r][k][0]) + DW'(prod6_ff[r][k][1]) + DW'(prod6_ff[r][k][2]);
            nr7_in[r*3+k] = RW'(dh6_pkg::rnd14(sum));
         end
         for (int j = 0; j < 3; j++) begin
            pp7_in[r][j] = $signed(lnk_ff[5].rot[r*3+j]) * lp6_ff[j];
         end
      end
   end

   always_comb begin
      logic signed [DW-1:0] acc;
      lnk8_in.ang = {16'h0, lnk_ff[6].ang[dh6_pkg::NUM_JOINTS-1:1]};
      for (int i = 0; i < 9; i++) begin
         lnk8_in.rot[i] = nr7_ff[i];
      end
      for (int r = 0; r < 3; r++) begin
         acc = DW'(pp7_ff[r][0]) + DW'(pp7_ff[r][1]) + DW'(pp7_ff[r][2]);
         lnk8_in.pos[r] = PW'(dh6_pkg::rnd14(acc)) + lnk_ff[6].pos[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lnk_ff[0] <= in_data;
         for (int k = 1; k < NS-1; k++) begin
            lnk_ff[k] <= lnk_ff[k-1];
         end
         lnk_ff[NS-1] <= lnk8_in;
         for (int u = 0; u < 2; u++) begin
            x1_ff[u]  <= fd_in[u].x;
            ng1_ff[u] <= fd_in[u].neg;
            xx1_ff[u] <= xx1_in[u];
            x2_ff[u]  <= x1_ff[u];
            ng2_ff[u] <= ng1_ff[u];
            q2_ff[u]  <= q2_in[u];
            p2_ff[u]  <= p2_in[u];
            x3_ff[u]  <= x2_ff[u];
            ng3_ff[u] <= ng2_ff[u];
            p3_ff[u]  <= p3_in[u];
            ng4_ff[u] <= ng3_ff[u];
            p4_ff[u]  <= p4_in[u];
            sc5_ff[u] <= sc5_in[u];
         end
         prod6_ff <= prod6_in;
         lp6_ff   <= lp6_in;
         nr7_ff   <= nr7_in;
         pp7_ff   <= pp7_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_data  = lnk_ff[NS-1];

endmodule

`default_nettype wire

// File: rtl/dh_forward_kinematics_6dof.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_6dof
// Six-joint DH forward kinematics: joint angles in, end-effector rotation
// (Q1.14) and position (Q15.8) out, through a chain of six joint cells.
//
//   channel | direction | payload
//   req_    | in        | six joint angles, 96 bits
//   rsp_    | out       | nine rotation entries, three positions, 216 bits
//   csr_    | in        | register write, index 0..7
//
// One transfer per cycle, sustained while rsp_tready is high. The path has 49
// register stages: eight stages in each of the six joint cells (five for the
// sine polynomial, three for the matrix product) plus the output register.
// Synchronous reset empties the pipeline and loads the register defaults. A
// stalled result holds the whole chain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dh_forward_kinematics_6dof_defines.svh"

module dh_forward_kinematics_6dof #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // joint_one_angle, joint_two_angle, ..., joint_six_angle (16 bits each)
   input  wire logic [95:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rot_xx, rot_xy, rot_xz, rot_yx, ..., rot_zz (16 bits each),
   // pos_x, pos_y, pos_z (24 bits each)
   output logic [215:0]      rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam int NJ = dh6_pkg::NUM_JOINTS;
   localparam int RW = dh6_pkg::ROT_W;
   localparam int DW = dh6_pkg::RND_W;
   localparam logic [31:0] KEEP = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
   localparam logic [15:0] ANG_MASK = KEEP[31:16];

   logic [15:0] base_height_ff, upper_arm_ff, elbow_len_ff;
   logic [15:0] forearm_ff, wrist_ff, tool_ff, shoulder_off_ff, elbow_off_ff;

   logic               en;
   logic               chain_valid [NJ+1];
   dh6_pkg::link_type  chain_data [NJ+1];
   logic [15:0]        len_a [NJ];
   logic [15:0]        len_d [NJ];
   logic               rsp_valid_ff;
   logic [215:0]       rsp_data_ff;
   logic [215:0]       rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff  <= 16'd6835;
         upper_arm_ff    <= 16'd7411;
         elbow_len_ff    <= 16'd1984;
         forearm_ff      <= 16'd8768;
         wrist_ff        <= 16'd1946;
         tool_ff         <= 16'd2483;
         shoulder_off_ff <= 16'(-14445);
         elbow_off_ff    <= 16'd14445;
      end else if (csr_wr_en) begin
         case (dh6_pkg::csr_index_type'(csr_index))
            dh6_pkg::CSR_BASE_HEIGHT:      base_height_ff  <= csr_wdata;
            dh6_pkg::CSR_UPPER_ARM_LENGTH: upper_arm_ff    <= csr_wdata;
            dh6_pkg::CSR_ELBOW_LENGTH:     elbow_len_ff    <= csr_wdata;
            dh6_pkg::CSR_FOREARM_OFFSET:   forearm_ff      <= csr_wdata;
            dh6_pkg::CSR_WRIST_LENGTH:     wrist_ff        <= csr_wdata;
            dh6_pkg::CSR_TOOL_OFFSET:      tool_ff         <= csr_wdata;
            dh6_pkg::CSR_SHOULDER_OFFSET:  shoulder_off_ff <= csr_wdata;
            dh6_pkg::CSR_ELBOW_OFFSET:     elbow_off_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign len_a = '{16'h0, 16'h0, upper_arm_ff, elbow_len_ff, 16'h0, wrist_ff};
   assign len_d = '{base_height_ff, 16'h0, 16'h0, forearm_ff, 16'h0, tool_ff};

   always_comb begin
      chain_valid[0] = req_tvalid;
      chain_data[0].ang[0] = req_tdata[15:0] & ANG_MASK;
      chain_data[0].ang[1] = (req_tdata[31:16] + shoulder_off_ff) & ANG_MASK;
      chain_data[0].ang[2] = (req_tdata[47:32] + elbow_off_ff) & ANG_MASK;
      chain_data[0].ang[3] = req_tdata[63:48] & ANG_MASK;
      chain_data[0].ang[4] = req_tdata[79:64] & ANG_MASK;
      chain_data[0].ang[5] = req_tdata[95:80] & ANG_MASK;
      for (int i = 0; i < 9; i++) begin
         chain_data[0].rot[i] = (i % 4 == 0) ? RW'(16384) : '0;
      end
      for (int r = 0; r < 3; r++) begin
         chain_data[0].pos[r] = '0;
      end
   end

   for (genvar g = 0; g < NJ; g++) begin : g_joint
      dh6_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .len_a     (len_a[g]),
         .len_d     (len_d[g]),
         .tw_cos    (dh6_pkg::TW_COS[g]),
         .tw_sin    (dh6_pkg::TW_SIN[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   always_comb begin
      logic signed [RW-1:0] rv;
      logic signed [DW-1:0] pv;
      for (int i = 0; i < 9; i++) begin
         rv = $signed(chain_data[NJ].rot[i]);
         if (rv > RW'(16384)) begin
            rsp_data_in[i*16 +: 16] = 16'd16384;
         end else if (rv < -RW'(16384)) begin
            rsp_data_in[i*16 +: 16] = 16'(-16384);
         end else begin
            rsp_data_in[i*16 +: 16] = rv[15:0];
         end
      end
      for (int r = 0; r < 3; r++) begin
         pv = dh6_pkg::rnd14(DW'($signed(chain_data[NJ].pos[r])));
         if (pv > DW'(8388607)) begin
            rsp_data_in[144 + r*24 +: 24] = 24'h7F_FFFF;
         end else if (pv < -DW'(8388608)) begin
            rsp_data_in[144 + r*24 +: 24] = 24'h80_0000;
         end else begin
            rsp_data_in[144 + r*24 +: 24] = pv[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain_valid[NJ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DH6_ASSERT_IMPLY(a_rot_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[15:0]) <= 16384) && ($signed(rsp_tdata[15:0]) >= -16384))
   `DH6_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(chain_valid[NJ]) && $stable(chain_data[NJ]))

endmodule

`default_nettype wire
